// File: sv/nspr_pkg.sv
package nspr_pkg;

  // address and coordinate widths
  localparam int ADDR_BITS  = 24;
  localparam int COORD_BITS = 16;

  // fixed field widths
  localparam int CLIP_BITS   = 13;
  localparam int WIDTH_BITS  = 13;
  localparam int STRIDE_BITS = 12;
  localparam int NIB_BITS    = 4;
  localparam int BYTE_BITS   = 2 * NIB_BITS;
  localparam int EN_BITS     = 2;

  // column arithmetic: start plus width plus a step of two, signed
  localparam int COL_W  = ((COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS) + 2;
  // visible columns lie below 2^CLIP_BITS, so a byte offset has CLIP_BITS-1 bits
  localparam int OFS_W  = CLIP_BITS - 1;
  localparam int PROD_W = CLIP_BITS + STRIDE_BITS;

  localparam logic signed [COL_W-1:0] COL_ONE = COL_W'(1);
  localparam logic signed [COL_W-1:0] COL_TWO = COL_W'(2);

  // slave tdata layout
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = COORD_BITS;
  localparam int W_LSB     = 2 * COORD_BITS;
  localparam int SRC_LSB   = W_LSB + WIDTH_BITS;
  localparam int IN_BITS   = SRC_LSB + BYTE_BITS;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // master tdata layout
  localparam int DATA_LSB  = ADDR_BITS;
  localparam int EN_LSB    = ADDR_BITS + BYTE_BITS;
  localparam int OUT_BITS  = EN_LSB + EN_BITS;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // nibble enables
  localparam logic [EN_BITS-1:0] EN_LOW = 2'b01;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;
  localparam int CRED_W     = CNT_W + 1;

  typedef enum logic [2:0] {
    CFG_CLIP_LEFT   = 3'd0,
    CFG_CLIP_TOP    = 3'd1,
    CFG_CLIP_RIGHT  = 3'd2,
    CFG_CLIP_BOTTOM = 3'd3,
    CFG_FRAME_BASE  = 3'd4,
    CFG_ROW_STRIDE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CLIP_BITS-1:0]   clip_left;
    logic [CLIP_BITS-1:0]   clip_top;
    logic [CLIP_BITS-1:0]   clip_right;
    logic [CLIP_BITS-1:0]   clip_bottom;
    logic [ADDR_BITS-1:0]   frame_base;
    logic [STRIDE_BITS-1:0] row_stride;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    clip_left:   '0,
    clip_top:    '0,
    clip_right:  CLIP_BITS'(4096),
    clip_bottom: CLIP_BITS'(4096),
    frame_base:  '0,
    row_stride:  STRIDE_BITS'(2048)
  };

  // one byte write before the row address is added
  typedef struct packed {
    logic [OFS_W-1:0]     ofs;
    logic [BYTE_BITS-1:0] data;
    logic [EN_BITS-1:0]   en;
    logic                 done;
  } slot_t;

  // up to two writes of one item, packed to the front
  typedef struct packed {
    logic  a_vld;
    slot_t a;
    logic  b_vld;
    slot_t b;
  } slots_t;

  typedef struct packed {
    logic              new_row;
    logic [PROD_W-1:0] prod;
    slots_t            slots;
  } stage_t;

  // finished byte write
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [BYTE_BITS-1:0] data;
    logic [EN_BITS-1:0]   en;
    logic                 done;
  } wr_t;

  typedef struct packed {
    logic a_vld;
    wr_t  a;
    logic b_vld;
    wr_t  b;
  } push_t;

endpackage

// File: sv/nspr_span.sv
module nspr_span (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_xfer_i,
  input  logic                              in_begin_i,
  input  logic [nspr_pkg::S_TDATA_W-1:0]    in_data_i,
  input  nspr_pkg::cfg_t                    cfg_i,
  output logic                              busy_o,
  output nspr_pkg::stage_t                  stage_o
);
  import nspr_pkg::*;

  // input register
  logic                         in_vld_q;
  logic                         begin_q;
  logic [COORD_BITS-1:0]        sx_q, sy_q;
  logic [WIDTH_BITS-1:0]        w_q;
  logic [BYTE_BITS-1:0]         src_q;

  // span state
  logic                         act_q, act_d;
  logic                         rv_q, rv_d;
  logic                         pv_q, pv_d;
  logic [NIB_BITS-1:0]          pn_q, pn_d;
  logic [COL_W-2:0]             nc_q, nc_d;
  logic [COL_W-2:0]             ec_q, ec_d;

  stage_t                       stage_q, stage_d;

  logic signed [COL_W-1:0]      sx_ext, sy_ext, w_ext, lft, rgt, top, bot;
  logic signed [COL_W-1:0]      nc, ec, c0, c1, c2;
  logic                         act, rv, pv, row_vis, v0, v1, last, odd, run;
  logic [NIB_BITS-1:0]          pn, lo, hi;
  slot_t                        r0, r1;
  logic                         r0_vld, r1_vld;

  function automatic logic col_vis(input logic signed [COL_W-1:0] c,
                                   input logic signed [COL_W-1:0] e,
                                   input logic signed [COL_W-1:0] l,
                                   input logic signed [COL_W-1:0] r);
    return (c < e) && (c >= l) && (c < r);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_xfer_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer_i) begin
      begin_q <= in_begin_i;
      sx_q    <= in_data_i[X_LSB +: COORD_BITS];
      sy_q    <= in_data_i[Y_LSB +: COORD_BITS];
      w_q     <= in_data_i[W_LSB +: WIDTH_BITS];
      src_q   <= in_data_i[SRC_LSB +: BYTE_BITS];
    end
  end

  always_comb begin
    sx_ext  = {{(COL_W-COORD_BITS){sx_q[COORD_BITS-1]}}, sx_q};
    sy_ext  = {{(COL_W-COORD_BITS){sy_q[COORD_BITS-1]}}, sy_q};
    w_ext   = {{(COL_W-WIDTH_BITS){1'b0}}, w_q};
    lft     = {{(COL_W-CLIP_BITS){1'b0}}, cfg_i.clip_left};
    rgt     = {{(COL_W-CLIP_BITS){1'b0}}, cfg_i.clip_right};
    top     = {{(COL_W-CLIP_BITS){1'b0}}, cfg_i.clip_top};
    bot     = {{(COL_W-CLIP_BITS){1'b0}}, cfg_i.clip_bottom};
    row_vis = (sy_ext >= top) && (sy_ext < bot);
    lo      = src_q[NIB_BITS-1:0];
    hi      = src_q[BYTE_BITS-1:NIB_BITS];

    // state as seen by this item, after a span start
    act = act_q;
    rv  = rv_q;
    pv  = pv_q;
    pn  = pn_q;
    nc  = {nc_q[COL_W-2], nc_q};
    ec  = {ec_q[COL_W-2], ec_q};
    if (in_vld_q && begin_q) begin
      act = (w_q != '0);
      rv  = row_vis;
      pv  = 1'b0;
      pn  = '0;
      nc  = sx_ext;
      ec  = sx_ext + w_ext;
    end

    c0   = nc;
    c1   = nc + COL_ONE;
    c2   = nc + COL_TWO;
    v0   = rv && col_vis(c0, ec, lft, rgt);
    v1   = rv && col_vis(c1, ec, lft, rgt);
    last = (c2 >= ec);
    odd  = c0[0];
    run  = in_vld_q && act;

    r0.ofs  = c0[OFS_W:1];
    r1.ofs  = c1[OFS_W:1];
    r1.data = {{NIB_BITS{1'b0}}, hi};
    r1.en   = EN_LOW;
    r1.done = last;
    if (odd) begin
      r0.data = {(v0 ? lo : {NIB_BITS{1'b0}}), (pv ? pn : {NIB_BITS{1'b0}})};
      r0.en   = {v0, pv};
    end else begin
      r0.data = {(v1 ? hi : {NIB_BITS{1'b0}}), (v0 ? lo : {NIB_BITS{1'b0}})};
      r0.en   = {v1, v0};
    end
    r0_vld  = run && (r0.en != '0);
    r1_vld  = run && odd && last && v1;
    r0.done = last && !r1_vld;

    act_d = act;
    rv_d  = rv;
    pv_d  = pv;
    pn_d  = pn;
    nc_d  = nc[COL_W-2:0];
    ec_d  = ec[COL_W-2:0];
    if (run) begin
      nc_d = c2[COL_W-2:0];
      if (odd) begin
        pn_d = hi;
        pv_d = v1;
      end
      if (last) begin
        act_d = 1'b0;
        pv_d  = 1'b0;
      end
    end

    stage_d.new_row     = in_vld_q && begin_q && row_vis;
    stage_d.prod        = PROD_W'(sy_ext[CLIP_BITS-1:0]) * PROD_W'(cfg_i.row_stride);
    stage_d.slots.a_vld = r0_vld || r1_vld;
    stage_d.slots.a     = r0_vld ? r0 : r1;
    stage_d.slots.b_vld = r0_vld && r1_vld;
    stage_d.slots.b     = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      pn_q    <= '0;
      nc_q    <= '0;
      ec_q    <= '0;
      stage_q <= '0;
    end else begin
      act_q   <= act_d;
      rv_q    <= rv_d;
      pv_q    <= pv_d;
      pn_q    <= pn_d;
      nc_q    <= nc_d;
      ec_q    <= ec_d;
      stage_q <= stage_d;
    end
  end

  assign busy_o  = in_vld_q;
  assign stage_o = stage_q;

endmodule

// File: sv/nspr_addr.sv
module nspr_addr (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nspr_pkg::stage_t               stage_i,
  input  logic [nspr_pkg::ADDR_BITS-1:0] frame_base_i,
  output nspr_pkg::push_t                push_o
);
  import nspr_pkg::*;

  logic [ADDR_BITS-1:0] row_q, row_d;
  slots_t               s3_q;

  // row base follows the item that enters this stage
  assign row_d = stage_i.new_row ? (frame_base_i + ADDR_BITS'(stage_i.prod)) : row_q;

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q <= stage_i.slots;
    end
  end

  always_comb begin
    push_o.a_vld  = s3_q.a_vld;
    push_o.a.addr = row_q + ADDR_BITS'(s3_q.a.ofs);
    push_o.a.data = s3_q.a.data;
    push_o.a.en   = s3_q.a.en;
    push_o.a.done = s3_q.a.done;
    push_o.b_vld  = s3_q.b_vld;
    push_o.b.addr = row_q + ADDR_BITS'(s3_q.b.ofs);
    push_o.b.data = s3_q.b.data;
    push_o.b.en   = s3_q.b.en;
    push_o.b.done = s3_q.b.done;
  end

endmodule

// File: sv/nspr_fifo.sv
module nspr_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nspr_pkg::push_t            push_i,
  input  logic                       pop_i,
  output nspr_pkg::wr_t              head_o,
  output logic [nspr_pkg::CNT_W-1:0] count_o
);
  import nspr_pkg::*;

  wr_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [1:0]         n_push;

  assign n_push = {1'b0, push_i.a_vld} + {1'b0, push_i.b_vld};

  always_ff @(posedge clk_i) begin
    if (push_i.a_vld) begin
      mem[wr_q] <= push_i.a;
    end
    if (push_i.b_vld) begin
      mem[wr_q + FIFO_AW'(1)] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FIFO_AW'(n_push);
      rd_q  <= rd_q + FIFO_AW'(pop_i);
      cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop_i);
    end
  end

  assign head_o  = mem[rd_q];
  assign count_o = cnt_q;

endmodule

// File: sv/nibble_span_put_realign.sv
// path: input register, span stage register, address stage register, result queue
// throughput: one source byte per cycle; one write per cycle while m_axis_tready
//   is high, via an 8-entry queue; input stalls only when the queue is near full
// reset: rst_ni asynchronous, active low; clears span state, queue and pipeline
//   valids, and loads the clip window, frame base and row stride defaults
module nibble_span_put_realign (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // source bytes
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // span_x, span_y, span_width, src_byte (lowest bit up), zero padded
  input  logic [nspr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // begin_span
  input  logic                              s_axis_tuser,
  // framebuffer byte writes
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // write_addr, write_data, nibble_enable (lowest bit up), zero padded
  output logic [nspr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // span_done
  output logic                              m_axis_tlast,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_addr_i,
  input  logic [nspr_pkg::ADDR_BITS-1:0]    cfg_wdata_i
);
  import nspr_pkg::*;

  cfg_t               cfg_q;
  logic               in_xfer;
  logic               in_busy;
  stage_t             stage;
  push_t              push;
  wr_t                head;
  logic [CNT_W-1:0]   count;
  logic [1:0]         n_s2, n_s3;
  logic [CRED_W-1:0]  committed;
  logic               pop;

  // configuration register file, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_wdata_i[CLIP_BITS-1:0];
        CFG_CLIP_TOP:    cfg_q.clip_top    <= cfg_wdata_i[CLIP_BITS-1:0];
        CFG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_wdata_i[CLIP_BITS-1:0];
        CFG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_wdata_i[CLIP_BITS-1:0];
        CFG_FRAME_BASE:  cfg_q.frame_base  <= cfg_wdata_i;
        CFG_ROW_STRIDE:  cfg_q.row_stride  <= cfg_wdata_i[STRIDE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // credit check: queue fill plus writes still in the pipeline plus two for
  // the byte being taken now must fit; the byte in the input register is
  // counted at its worst case of two writes
  assign n_s2      = {1'b0, stage.slots.a_vld} + {1'b0, stage.slots.b_vld};
  assign n_s3      = {1'b0, push.a_vld} + {1'b0, push.b_vld};
  assign committed = CRED_W'(count) + CRED_W'({in_busy, 1'b0}) + CRED_W'(n_s2)
                   + CRED_W'(n_s3) + CRED_W'(2);

  assign s_axis_tready = (committed <= CRED_W'(FIFO_DEPTH));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // stage one: span state, clipping and nibble realignment
  nspr_span u_span (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_xfer_i  (in_xfer),
    .in_begin_i (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_i      (cfg_q),
    .busy_o     (in_busy),
    .stage_o    (stage)
  );

  // stages two and three: row base, then byte address
  nspr_addr u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (stage),
    .frame_base_i (cfg_q.frame_base),
    .push_o       (push)
  );

  // result queue, up to two writes in and one out per cycle
  nspr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign m_axis_tvalid = (count != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = M_TDATA_W'({head.en, head.data, head.addr});
  assign m_axis_tlast  = head.done;

endmodule

// File: sv/nspr_checker.sv
module nspr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [nspr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input logic                              m_axis_tlast
);
  import nspr_pkg::*;

  logic [EN_BITS-1:0]   en;
  logic [BYTE_BITS-1:0] dat;

  assign en  = m_axis_tdata[EN_LSB +: EN_BITS];
  assign dat = m_axis_tdata[DATA_LSB +: BYTE_BITS];

  // a pending write stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("write withdrawn while stalled");

  // a stalled write keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("write payload changed while stalled");

  // every write touches at least one nibble
  a_enable_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> en != '0)
    else $error("write with no nibble enabled");

  // disabled nibbles carry zero
  a_masked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (en[0] || dat[NIB_BITS-1:0] == '0)
                   && (en[1] || dat[BYTE_BITS-1:NIB_BITS] == '0))
    else $error("disabled nibble not zero");

endmodule

bind nibble_span_put_realign nspr_checker u_checker (.*);
